// ----- hw/rtl/cutoff_polynomial_pair_correlation_macros.svh -----
// Assertion macros for the cutoff polynomial pair correlation block.
// Taken in by the RTL files that carry concurrent assertions.
`ifndef CUTOFF_POLYNOMIAL_PAIR_CORRELATION_MACROS_SVH
`define CUTOFF_POLYNOMIAL_PAIR_CORRELATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CPC_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("cpc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CPC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("cpc: next-cycle check failed");

`endif

// ----- hw/rtl/cpc_pkg.sv -----
// Shared types, widths, register codes and helper functions for the cutoff
// polynomial pair correlation block. No dependencies.
package cpc_pkg;

  localparam int NUM_COEFS_DEF = 5;
  localparam int MAX_COEFS     = 5;
  localparam int MUL_LAT       = 4;

  localparam int W_DIST  = 32;
  localparam int W_FL    = 31;
  localparam int W_C     = 2;
  localparam int W_COEF  = 48;
  localparam int W_RES   = 48;
  localparam int W_IDX   = 4;
  localparam int W_DATA  = 48;
  localparam int W_POLY  = 53;
  localparam int W_SAT   = 72;
  localparam int W_CIDX  = 3;

  localparam logic [W_FL-1:0] FL_RESET = 31'd16777216;
  localparam logic [W_C-1:0]  C_RESET  = 2'd3;

  localparam logic signed [W_SAT-1:0] SAT_HI = 72'sh000000_7FFFFFFFFFFF;
  localparam logic signed [W_SAT-1:0] SAT_LO = 72'shFFFFFF_800000000000;

  typedef enum logic [W_IDX-1:0] {
    CFG_SCALE_FL = 4'd0,
    CFG_POWER_C  = 4'd1,
    CFG_ENABLE   = 4'd2,
    CFG_COEF0    = 4'd3,
    CFG_COEF1    = 4'd4,
    CFG_COEF2    = 4'd5,
    CFG_COEF3    = 4'd6,
    CFG_COEF4    = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [W_RES-1:0] val;
    logic                    clip;
  } sat_t;

  typedef struct packed {
    logic signed [W_RES-1:0] value;
    logic signed [W_RES-1:0] first_deriv;
    logic signed [W_RES-1:0] second_deriv;
    logic                    inside_cutoff;
    logic                    saturated;
  } res_t;

  function automatic sat_t sat48(input logic signed [W_SAT-1:0] v);
    sat_t s;
    if (v > SAT_HI) begin
      s.val  = SAT_HI[W_RES-1:0];
      s.clip = 1'b1;
    end else if (v < SAT_LO) begin
      s.val  = SAT_LO[W_RES-1:0];
      s.clip = 1'b1;
    end else begin
      s.val  = v[W_RES-1:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

  function automatic logic signed [W_POLY-1:0] kscale(input logic signed [W_COEF-1:0] c,
                                                      input logic [3:0] f);
    logic signed [W_POLY-1:0] ce;
    logic signed [4:0]        fs;
    ce = W_POLY'(c);
    fs = {1'b0, f};
    return ce * fs;
  endfunction

endpackage

// ----- hw/rtl/cpc_if.sv -----
// Request channels of the cutoff polynomial pair correlation block:
// distance input, result output and register write. Depends on cpc_pkg.
interface cpc_in_if;
  import cpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [W_DIST-1:0] distance;
  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

interface cpc_out_if;
  import cpc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [W_RES-1:0] value;
  logic signed [W_RES-1:0] first_deriv;
  logic signed [W_RES-1:0] second_deriv;
  logic                    inside_cutoff;
  logic                    saturated;
  modport source (output valid, output value, output first_deriv, output second_deriv,
                  output inside_cutoff, output saturated, input ready);
  modport sink (input valid, input value, input first_deriv, input second_deriv,
                input inside_cutoff, input saturated, output ready);
endinterface

interface cpc_cfg_if;
  import cpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [W_IDX-1:0]  index;
  logic [W_DATA-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/cpc_delay.sv -----
// Enabled delay line for pipeline payload alignment.
// Depends on nothing.
module cpc_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  if (D == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [W-1:0] line [D];
    always_ff @(posedge clk) begin
      if (en) begin
        line[0] <= d;
        for (int i = 1; i < D; i++) begin
          line[i] <= line[i-1];
        end
      end
    end
    assign q = line[D-1];
  end
endmodule

// ----- hw/rtl/cpc_mulsh.sv -----
// Four-stage signed multiplier: exact product, shift right by SH with the
// magnitude rounded half away from zero. Depends on nothing.
module cpc_mulsh #(
  parameter int WA = 34,
  parameter int WB = 34,
  parameter int SH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [WA-1:0]     a,
  input  logic signed [WB-1:0]     b,
  output logic signed [WA+WB-SH-1:0] y
);
  localparam int AL = (WA + 1) / 2;
  localparam int BL = (WB + 1) / 2;
  localparam int PW = WA + WB;
  localparam int WO = PW - SH;
  localparam logic [PW-1:0] HALF = PW'(1) << (SH - 1);

  logic          neg1, neg2, neg3;
  logic [WA-1:0] ma;
  logic [WB-1:0] mb;
  logic [PW-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [PW-1:0] sum;
  logic [WO-1:0] mag;

  assign mag = sum[PW-1:SH];

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= a[WA-1] ^ b[WB-1];
      ma    <= a[WA-1] ? (~a + 1'b1) : a;
      mb    <= b[WB-1] ? (~b + 1'b1) : b;
      neg2  <= neg1;
      pp_ll <= PW'(ma[AL-1:0] * mb[BL-1:0]);
      pp_lh <= PW'(ma[AL-1:0] * mb[WB-1:BL]);
      pp_hl <= PW'(ma[WA-1:AL] * mb[BL-1:0]);
      pp_hh <= PW'(ma[WA-1:AL] * mb[WB-1:BL]);
      neg3  <= neg2;
      sum   <= pp_ll + (pp_lh << BL) + (pp_hl << AL) + (pp_hh << (AL + BL)) + HALF;
      y     <= neg3 ? (~mag + 1'b1) : mag;
    end
  end
endmodule

// ----- hw/rtl/cutoff_polynomial_pair_correlation.sv -----
// Cutoff polynomial pair correlation: per distance r forms x = fL*r and returns
// u = (x-1)^C P(x) with du/dr and d2u/dr2 in saturating Q16.32, zeros outside
// the cutoff or when disabled. Fully pipelined: one distance per cycle while the
// skid entry is empty; the depth is set by the Horner chain of multiply-add
// steps, each a four-stage multiplier plus an adder. A two-entry output buffer
// keeps the input open while one result waits and stalls it when both are full.
// Depends on cpc_pkg, cpc_if, cpc_delay, cpc_mulsh and the assertion macros.
`include "cutoff_polynomial_pair_correlation_macros.svh"

module cutoff_polynomial_pair_correlation #(
  parameter int NUM_COEFS = cpc_pkg::NUM_COEFS_DEF
) (
  input logic      clk,
  input logic      rst,
  cpc_cfg_if.sink  cfg,
  cpc_in_if.sink   sample,
  cpc_out_if.source result
);
  import cpc_pkg::*;

  localparam int WX    = 34;
  localparam int WP    = W_POLY;
  localparam int WPM   = WP + WX - 32;
  localparam int WU    = 56;
  localparam int WF1   = 32 + WU - 24;
  localparam int WF2   = 63 + WU - 48;
  localparam int W_X48 = W_FL + W_DIST;
  localparam int STEP_LAT = MUL_LAT + 1;
  localparam int HORNER_LAT = (NUM_COEFS - 1) * STEP_LAT;
  localparam int POW_LAT = 2 * MUL_LAT;
  localparam int ALIGN = (HORNER_LAT > POW_LAT) ? HORNER_LAT : POW_LAT;
  localparam int DEPTH = 6 + ALIGN + 2 * MUL_LAT;
  localparam logic [W_X48-1:0] X48_ONE = W_X48'(1) << 48;
  localparam logic signed [WX-1:0] ONE_Q32 = 34'sh1_0000_0000;

  // configuration
  logic [W_FL-1:0]          scale_fl;
  logic [W_C-1:0]           power_c;
  logic                     enable;
  logic signed [W_COEF-1:0] coef [MAX_COEFS];
  logic [2*W_FL-1:0]        fl_sq;
  logic [W_CIDX-1:0]        cidx;

  assign cfg.ready = 1'b1;
  assign cidx = W_CIDX'(cfg.index - CFG_COEF0);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_fl <= FL_RESET;
      power_c  <= C_RESET;
      enable   <= 1'b0;
      for (int k = 0; k < MAX_COEFS; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index) inside
        CFG_SCALE_FL:           scale_fl <= cfg.data[W_FL-1:0];
        CFG_POWER_C:            power_c <= cfg.data[W_C-1:0];
        CFG_ENABLE:             enable <= cfg.data[0];
        [CFG_COEF0:CFG_COEF4]:  coef[cidx] <= cfg.data[W_COEF-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fl_sq <= scale_fl * scale_fl;
  end

  // pipeline control
  logic             en;
  logic             skid_v;
  logic             ov;
  logic [DEPTH:1]   vld;
  res_t             obuf, skid, res;

  assign en = !skid_v;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-1:1], sample.valid};
    end
  end

  // front: x = fL*r, d = x - 1, cutoff test
  logic [W_DIST-1:0]      r1;
  logic [W_X48-1:0]       x48;
  logic signed [WX-1:0]   xq, d3;
  logic                   inside3;

  always_ff @(posedge clk) begin
    if (en) begin
      r1      <= sample.distance;
      x48     <= scale_fl * r1;
      xq      <= {1'b0, x48[48:16]};
      d3      <= {1'b0, x48[48:16]} - ONE_Q32;
      inside3 <= enable && (x48 <= X48_ONE);
    end
  end

  // powers of d
  logic signed [WX+1:0] sq_y, cu_y;
  logic signed [WX-1:0] pw2_7, d_7, pw3_11, pw2_11, d_11;
  logic signed [WX-1:0] pw2_a, pw3_a, d_a;

  cpc_mulsh #(.WA(WX), .WB(WX), .SH(32)) u_sq (.clk, .en, .a(d3), .b(d3), .y(sq_y));
  assign pw2_7 = sq_y[WX-1:0];
  cpc_delay #(.W(WX), .D(MUL_LAT)) u_dd7 (.clk, .en, .d(d3), .q(d_7));
  cpc_mulsh #(.WA(WX), .WB(WX), .SH(32)) u_cu (.clk, .en, .a(pw2_7), .b(d_7), .y(cu_y));
  assign pw3_11 = cu_y[WX-1:0];
  cpc_delay #(.W(WX), .D(MUL_LAT)) u_dp11 (.clk, .en, .d(pw2_7), .q(pw2_11));
  cpc_delay #(.W(WX), .D(MUL_LAT)) u_dd11 (.clk, .en, .d(d_7), .q(d_11));
  cpc_delay #(.W(WX), .D(ALIGN - POW_LAT)) u_ap2 (.clk, .en, .d(pw2_11), .q(pw2_a));
  cpc_delay #(.W(WX), .D(ALIGN - POW_LAT)) u_ap3 (.clk, .en, .d(pw3_11), .q(pw3_a));
  cpc_delay #(.W(WX), .D(ALIGN - POW_LAT)) u_apd (.clk, .en, .d(d_11), .q(d_a));

  // Horner chain for P, P', P''
  logic signed [WP-1:0] hp0 [NUM_COEFS];
  logic signed [WP-1:0] hp1 [NUM_COEFS];
  logic signed [WP-1:0] hp2 [NUM_COEFS];
  logic signed [WX-1:0] hx  [NUM_COEFS];

  assign hp0[0] = kscale(coef[NUM_COEFS-1], 4'd1);
  assign hp1[0] = kscale(coef[NUM_COEFS-1], 4'(NUM_COEFS - 1));
  assign hp2[0] = kscale(coef[NUM_COEFS-1], 4'((NUM_COEFS - 1) * (NUM_COEFS - 2)));
  assign hx[0]  = xq;

  for (genvar j = 0; j < NUM_COEFS - 1; j++) begin : g_step
    localparam int K = NUM_COEFS - 2 - j;
    logic signed [WPM-1:0] y0;
    logic signed [WP-1:0]  t0, t1, t2, n0, n1, n2;
    logic signed [WX-1:0]  xd, nx;

    cpc_mulsh #(.WA(WP), .WB(WX), .SH(32)) u_m0 (.clk, .en, .a(hp0[j]), .b(hx[j]), .y(y0));
    assign t0 = y0[WP-1:0] + kscale(coef[K], 4'd1);
    cpc_delay #(.W(WX), .D(MUL_LAT)) u_dx (.clk, .en, .d(hx[j]), .q(xd));

    if (K >= 1) begin : g_p1
      logic signed [WPM-1:0] y1;
      cpc_mulsh #(.WA(WP), .WB(WX), .SH(32)) u_m1 (.clk, .en, .a(hp1[j]), .b(hx[j]), .y(y1));
      assign t1 = y1[WP-1:0] + kscale(coef[K], 4'(K));
    end else begin : g_p1d
      cpc_delay #(.W(WP), .D(MUL_LAT)) u_d1 (.clk, .en, .d(hp1[j]), .q(t1));
    end

    if (K >= 2) begin : g_p2
      logic signed [WPM-1:0] y2;
      cpc_mulsh #(.WA(WP), .WB(WX), .SH(32)) u_m2 (.clk, .en, .a(hp2[j]), .b(hx[j]), .y(y2));
      assign t2 = y2[WP-1:0] + kscale(coef[K], 4'(K * (K - 1)));
    end else begin : g_p2d
      cpc_delay #(.W(WP), .D(MUL_LAT)) u_d2 (.clk, .en, .d(hp2[j]), .q(t2));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n0 <= t0;
        n1 <= t1;
        n2 <= t2;
        nx <= xd;
      end
    end

    assign hp0[j+1] = n0;
    assign hp1[j+1] = n1;
    assign hp2[j+1] = n2;
    assign hx[j+1]  = nx;
  end

  logic signed [WP-1:0] p0_a, p1_a, p2_a;
  cpc_delay #(.W(WP), .D(ALIGN - HORNER_LAT)) u_ah0 (.clk, .en, .d(hp0[NUM_COEFS-1]), .q(p0_a));
  cpc_delay #(.W(WP), .D(ALIGN - HORNER_LAT)) u_ah1 (.clk, .en, .d(hp1[NUM_COEFS-1]), .q(p1_a));
  cpc_delay #(.W(WP), .D(ALIGN - HORNER_LAT)) u_ah2 (.clk, .en, .d(hp2[NUM_COEFS-1]), .q(p2_a));

  // select d^C, d^(C-1), d^(C-2)
  logic signed [WX-1:0] pa, pb, pc, pa_next, pb_next, pc_next;
  logic signed [WP-1:0] p0_s, p1_s, p2_s;

  always_comb begin
    case (power_c)
      2'd0: begin
        pa_next = ONE_Q32;
        pb_next = '0;
        pc_next = '0;
      end
      2'd1: begin
        pa_next = d_a;
        pb_next = ONE_Q32;
        pc_next = '0;
      end
      2'd2: begin
        pa_next = pw2_a;
        pb_next = d_a;
        pc_next = ONE_Q32;
      end
      default: begin
        pa_next = pw3_a;
        pb_next = pw2_a;
        pc_next = d_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa   <= pa_next;
      pb   <= pb_next;
      pc   <= pc_next;
      p0_s <= p0_a;
      p1_s <= p1_a;
      p2_s <= p2_a;
    end
  end

  // cross products
  logic signed [WPM-1:0] m_a0, m_a1, m_a2, m_b0, m_b1, m_c0;
  cpc_mulsh #(.WA(WX), .WB(WP), .SH(32)) u_a0 (.clk, .en, .a(pa), .b(p0_s), .y(m_a0));
  cpc_mulsh #(.WA(WX), .WB(WP), .SH(32)) u_a1 (.clk, .en, .a(pa), .b(p1_s), .y(m_a1));
  cpc_mulsh #(.WA(WX), .WB(WP), .SH(32)) u_a2 (.clk, .en, .a(pa), .b(p2_s), .y(m_a2));
  cpc_mulsh #(.WA(WX), .WB(WP), .SH(32)) u_b0 (.clk, .en, .a(pb), .b(p0_s), .y(m_b0));
  cpc_mulsh #(.WA(WX), .WB(WP), .SH(32)) u_b1 (.clk, .en, .a(pb), .b(p1_s), .y(m_b1));
  cpc_mulsh #(.WA(WX), .WB(WP), .SH(32)) u_c0 (.clk, .en, .a(pc), .b(p0_s), .y(m_c0));

  logic signed [WU-1:0] a1, a2, b0, b1, c0, u1_next, u2_next, u1, u2;
  logic signed [WP-1:0] u;

  assign a1 = WU'(m_a1);
  assign a2 = WU'(m_a2);
  assign b0 = WU'(m_b0);
  assign b1 = WU'(m_b1);
  assign c0 = WU'(m_c0);

  always_comb begin
    case (power_c)
      2'd0: begin
        u1_next = a1;
        u2_next = a2;
      end
      2'd1: begin
        u1_next = a1 + b0;
        u2_next = a2 + (b1 <<< 1);
      end
      2'd2: begin
        u1_next = a1 + (b0 <<< 1);
        u2_next = a2 + (b1 <<< 2) + (c0 <<< 1);
      end
      default: begin
        u1_next = a1 + b0 + (b0 <<< 1);
        u2_next = a2 + (b1 <<< 2) + (b1 <<< 1) + (c0 <<< 2) + (c0 <<< 1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u  <= m_a0[WP-1:0];
      u1 <= u1_next;
      u2 <= u2_next;
    end
  end

  // scale to r domain
  logic signed [WF1-1:0] f1;
  logic signed [WF2-1:0] f2;
  logic signed [WP-1:0]  u_d;
  logic                  inside_d;
  logic signed [31:0]    fl_s;
  logic signed [62:0]    fl2_s;

  assign fl_s  = {1'b0, scale_fl};
  assign fl2_s = {1'b0, fl_sq};

  cpc_mulsh #(.WA(32), .WB(WU), .SH(24)) u_f1 (.clk, .en, .a(fl_s), .b(u1), .y(f1));
  cpc_mulsh #(.WA(63), .WB(WU), .SH(48)) u_f2 (.clk, .en, .a(fl2_s), .b(u2), .y(f2));
  cpc_delay #(.W(WP), .D(MUL_LAT)) u_du (.clk, .en, .d(u), .q(u_d));
  cpc_delay #(.W(1), .D(ALIGN + 2 * MUL_LAT + 2)) u_din (.clk, .en, .d(inside3), .q(inside_d));

  sat_t s0, s1, s2;
  res_t res_next;

  assign s0 = sat48(W_SAT'(u_d));
  assign s1 = sat48(W_SAT'(f1));
  assign s2 = sat48(W_SAT'(f2));

  always_comb begin
    res_next = '0;
    if (inside_d) begin
      res_next.value         = s0.val;
      res_next.first_deriv   = s1.val;
      res_next.second_deriv  = s2.val;
      res_next.inside_cutoff = 1'b1;
      res_next.saturated     = s0.clip | s1.clip | s2.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  // output register and skid entry
  logic fire;
  assign fire = ov && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov     <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (fire) begin
        skid_v <= 1'b0;
      end
    end else if (!ov || fire) begin
      ov <= vld[DEPTH];
    end else if (vld[DEPTH]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (fire) begin
        obuf <= skid;
      end
    end else if (!ov || fire) begin
      obuf <= res;
    end else begin
      skid <= res;
    end
  end

  assign result.valid         = ov;
  assign result.value         = obuf.value;
  assign result.first_deriv   = obuf.first_deriv;
  assign result.second_deriv  = obuf.second_deriv;
  assign result.inside_cutoff = obuf.inside_cutoff;
  assign result.saturated     = obuf.saturated;

  logic obuf_zero;
  assign obuf_zero = obuf.value == '0 && obuf.first_deriv == '0 &&
                     obuf.second_deriv == '0 && !obuf.saturated;

  `CPC_ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_v, ov)
  `CPC_ASSERT_NEXT(a_skid_drains, clk, rst, skid_v && result.ready, ov && !skid_v)
  `CPC_ASSERT_IMPLIES(a_outside_zero, clk, rst, ov && !obuf.inside_cutoff, obuf_zero)

endmodule

// ----- tb/tb_cutoff_polynomial_pair_correlation.sv -----
// Testbench for cutoff_polynomial_pair_correlation: streams distances through
// the block under random flow control and register settings, predicting u, du/dr
// and d2u/dr2 in fixed point. Depends on cpc_pkg, cpc_if and the block's RTL.
`timescale 1ns / 100ps

module tb_cutoff_polynomial_pair_correlation;
  import cpc_pkg::*;

  localparam int N_COEF = 5;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  cpc_cfg_if cfg_if ();
  cpc_in_if  sample_if ();
  cpc_out_if result_if ();

  cutoff_polynomial_pair_correlation DUT (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_if),
    .sample(sample_if),
    .result(result_if)
  );

  logic [W_FL-1:0] fl_reg;
  logic [W_C-1:0]  pow_reg;
  logic            en_reg;
  longint          coef_reg [N_COEF];
  logic            clip_flag;

  logic [W_DIST-1:0] pending_distances [$];
  res_t              expected_terms [$];
  int                src_idle_pct;
  int                snk_idle_pct;
  int                hold_requests;
  int                hold_served;
  int                hold_left;
  int                mismatches;
  int                cycles;

  function automatic longint mul_round(longint a, longint b, int s);
    logic          neg;
    logic [63:0]   ma;
    logic [63:0]   mb;
    logic [127:0]  p;
    logic [63:0]   res;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'b0, ma} * {64'b0, mb};
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    if (p > (128'd1 << 62)) begin
      clip_flag = 1'b1;
      res = 64'd1 << 62;
    end else begin
      res = p[63:0];
    end
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic [W_RES-1:0] clamp48(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< 47) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip_flag = 1'b1;
      v = hi;
    end
    if (v < lo) begin
      clip_flag = 1'b1;
      v = lo;
    end
    return v[W_RES-1:0];
  endfunction

  function automatic res_t correlation_term(logic [W_DIST-1:0] r);
    res_t   o;
    longint x48;
    longint xq;
    longint d;
    longint pw [4];
    longint p0;
    longint p1;
    longint p2;
    longint u;
    longint u1;
    longint u2;
    longint c;
    longint fl;
    o = '0;
    clip_flag = 1'b0;
    fl = longint'(fl_reg);
    x48 = fl * longint'({32'b0, r});
    if (!en_reg || x48 > (longint'(1) <<< 48)) return o;
    xq = x48 >>> 16;
    d = xq - (longint'(1) <<< 32);
    pw[0] = longint'(1) <<< 32;
    pw[1] = d;
    pw[2] = mul_round(d, d, 32);
    pw[3] = mul_round(pw[2], d, 32);
    p0 = 0;
    p1 = 0;
    p2 = 0;
    for (int k = N_COEF - 1; k >= 0; k--) begin
      p0 = mul_round(p0, xq, 32) + coef_reg[k];
      if (k >= 1) p1 = mul_round(p1, xq, 32) + longint'(k) * coef_reg[k];
      if (k >= 2) p2 = mul_round(p2, xq, 32) + longint'(k * (k - 1)) * coef_reg[k];
    end
    c = longint'(pow_reg);
    u = mul_round(pw[c], p0, 32);
    u1 = mul_round(pw[c], p1, 32);
    u2 = mul_round(pw[c], p2, 32);
    if (c >= 1) begin
      u1 += c * mul_round(pw[c - 1], p0, 32);
      u2 += (2 * c) * mul_round(pw[c - 1], p1, 32);
    end
    if (c >= 2) u2 += (c * (c - 1)) * mul_round(pw[c - 2], p0, 32);
    o.value = clamp48(u);
    o.first_deriv = clamp48(mul_round(fl, u1, 24));
    o.second_deriv = clamp48(mul_round(fl * fl, u2, 48));
    o.inside_cutoff = 1'b1;
    o.saturated = clip_flag;
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      sample_if.distance <= '0;
    end else if (!sample_if.valid || sample_if.ready) begin
      if (sample_if.valid) expected_terms.push_back(correlation_term(sample_if.distance));
      if (pending_distances.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        sample_if.valid <= 1'b1;
        sample_if.distance <= pending_distances.pop_front();
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= 400;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got.value = result_if.value;
      got.first_deriv = result_if.first_deriv;
      got.second_deriv = result_if.second_deriv;
      got.inside_cutoff = result_if.inside_cutoff;
      got.saturated = result_if.saturated;
      if (expected_terms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_terms.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp u=%h du=%h d2u=%h in=%b sat=%b",
                     want.value, want.first_deriv, want.second_deriv,
                     want.inside_cutoff, want.saturated);
            $display("          got u=%h du=%h d2u=%h in=%b sat=%b",
                     got.value, got.first_deriv, got.second_deriv,
                     got.inside_cutoff, got.saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[cutoff_polynomial_pair_correlation] ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [W_DATA-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_SCALE_FL: fl_reg = data[W_FL-1:0];
      CFG_POWER_C:  pow_reg = data[W_C-1:0];
      CFG_ENABLE:   en_reg = data[0];
      default:      coef_reg[idx - CFG_COEF0] = longint'(signed'(data[W_COEF-1:0]));
    endcase
  endtask

  task automatic settle();
    @(negedge clk);
    wait (pending_distances.size() == 0 && !sample_if.valid && expected_terms.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic send(logic [W_DIST-1:0] r);
    @(negedge clk);
    pending_distances.push_back(r);
  endtask

  function automatic logic [W_DATA-1:0] rand_coef();
    case ($urandom_range(3))
      0: return 48'({$urandom, $urandom});
      1: return 48'(longint'($urandom_range(2000000)) * 4096 - 64'd4096000000);
      2: return {$urandom_range(1) ? 16'h7FFF : 16'h8000, $urandom};
      default: return 48'(longint'($urandom_range(65536)) - 32768);
    endcase
  endfunction

  function automatic logic [W_DIST-1:0] rand_distance();
    longint lim;
    if (fl_reg == 0 || $urandom_range(9) == 0) return $urandom;
    lim = (longint'(1) <<< 48) / longint'(fl_reg) + 2;
    if (lim > 64'hFFFFFFFF) lim = 64'hFFFFFFFF;
    return 32'(({$urandom, $urandom} & 64'h7FFFFFFFFFFFFFFF) % (lim + 1));
  endfunction

  initial begin
    logic [W_DIST-1:0] edge_r [6];
    rst = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    sample_if.valid = 1'b0;
    sample_if.distance = '0;
    result_if.ready = 1'b0;
    fl_reg = FL_RESET;
    pow_reg = C_RESET;
    en_reg = 1'b0;
    for (int k = 0; k < N_COEF; k++) coef_reg[k] = 0;
    src_idle_pct = 6;
    snk_idle_pct = 70;
    hold_requests = 0;
    mismatches = 0;
    cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(32'd0);
    send(32'hFFFFFFFF);
    send(32'h01000000);
    settle();

    write_reg(CFG_ENABLE, 48'd1);
    write_reg(CFG_COEF0, 48'h000100000000);
    write_reg(CFG_COEF1, 48'h7FFFFFFFFFFF);
    write_reg(CFG_COEF2, 48'h800000000000);
    write_reg(CFG_COEF3, 48'hFFFF80000000);
    write_reg(CFG_COEF4, 48'h000000012345);
    edge_r = '{32'd0, 32'hFFFFFFFF, 32'h01000000, 32'h01000001, 32'h00FFFFFF, 32'h00800000};
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_POWER_C, 48'(3 - p));
      for (int i = 0; i < 5; i++) send(edge_r[i]);
      settle();
    end
    write_reg(CFG_POWER_C, 48'd2);
    write_reg(CFG_SCALE_FL, 48'd0);
    send(32'hFFFFFFFF);
    send(32'h12345678);
    settle();
    write_reg(CFG_SCALE_FL, 48'h7FFFFFFF);
    send(32'd0);
    send(32'd1);
    send(32'h00020000);
    settle();
    write_reg(CFG_SCALE_FL, 48'd1677721600);
    send(32'd0);
    send(32'h00028F5C);
    send(32'h00028F5D);
    send(32'h00014000);
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 70;
        snk_idle_pct = 6;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (ph % 3)
        0: write_reg(CFG_SCALE_FL, 48'($urandom_range(32'h01000000, 32'h04000000)));
        1: write_reg(CFG_SCALE_FL, 48'($urandom_range(32'h00400000, 32'h01000000)));
        default: write_reg(CFG_SCALE_FL, 48'($urandom_range(1677721600)));
      endcase
      write_reg(CFG_POWER_C, 48'($urandom_range(9) == 0 ? $urandom_range(1) :
                                  $urandom_range(2, 3)));
      write_reg(CFG_ENABLE, 48'(ph != 4));
      for (int k = 0; k < N_COEF; k++) write_reg(cfg_idx_t'(CFG_COEF0 + k), rand_coef());
      if (ph == 1) begin
        @(negedge clk);
        hold_requests = hold_requests + 1;
      end
      for (int i = 0; i < 135; i++) send(rand_distance());
      settle();
    end

    settle();
    if (mismatches == 0 && expected_terms.size() == 0) begin
      $display("[cutoff_polynomial_pair_correlation] OK");
    end else begin
      $display("[cutoff_polynomial_pair_correlation] ERROR");
    end
    $finish;
  end

endmodule
